>>> rtl/core/mssq_pkg.sv
`default_nettype none

package mssq_pkg;

  // Fixed field widths of the pixel and result words.
  localparam int unsigned SideW = 11;
  localparam int unsigned AreaW = 21;
  localparam int unsigned CfgW  = 11;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [SideW-1:0] SideMax = {SideW{1'b1}};
  localparam logic [AreaW-1:0] AreaMax = {AreaW{1'b1}};

  localparam int unsigned DefMaxWidth  = 1024;
  localparam int unsigned DefMaxHeight = 1024;

  localparam logic [CfgW-1:0] ResetImageWidth  = 11'd1024;
  localparam logic [CfgW-1:0] ResetImageHeight = 11'd1024;

  typedef enum logic [CfgIdxW-1:0] {
    CfgImageWidth  = 1'b0,
    CfgImageHeight = 1'b1
  } cfg_idx_e;

  // One result word as it leaves the core.
  typedef struct packed {
    logic [SideW-1:0] side_here;
    logic [SideW-1:0] best_side;
    logic             frame_done;
  } res_t;

  function automatic logic [SideW-1:0] min3(input logic [SideW-1:0] a,
                                            input logic [SideW-1:0] b,
                                            input logic [SideW-1:0] c);
    logic [SideW-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/mssq_ram.sv
`default_nettype none

module mssq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> rtl/core/mssq_core.sv
`default_nettype none

module mssq_core
  import mssq_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = DefMaxHeight
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_wdata_i,
  input  wire logic               acc_i,
  input  wire logic               pixel_i,
  output res_t                    res_o
);

  localparam int unsigned ColW = $clog2(MAX_WIDTH);
  localparam int unsigned RowW = $clog2(MAX_HEIGHT);

  logic [CfgW-1:0]  width_q, height_q;
  logic [ColW-1:0]  col_q, col_d, col_next, raddr;
  logic [RowW-1:0]  row_q, row_d;
  logic [SideW-1:0] left_q, left_d, diag_q, diag_d, best_q, best_d;
  logic [SideW-1:0] byp_q, rdata, up, nb_min, side, best_new;
  logic             byp_vld_q;
  logic [31:0]      w_eff, h_eff;
  logic             row_end, frame_end, first;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ResetImageWidth;
      height_q <= ResetImageHeight;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgImageWidth:  width_q  <= cfg_wdata_i;
        CfgImageHeight: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // A zero dimension acts as one, an oversized one as the maximum.
  always_comb begin
    if (width_q == '0) begin
      w_eff = 32'd1;
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      w_eff = 32'(MAX_WIDTH);
    end else begin
      w_eff = 32'(width_q);
    end
    if (height_q == '0) begin
      h_eff = 32'd1;
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      h_eff = 32'(MAX_HEIGHT);
    end else begin
      h_eff = 32'(height_q);
    end
  end

  assign row_end   = (32'(col_q) + 32'd1) >= w_eff;
  assign frame_end = row_end && ((32'(row_q) + 32'd1) >= h_eff);
  assign col_next  = row_end ? '0 : col_q + 1'b1;

  // The line buffer is read one column ahead: on an accepted word the
  // address moves to the next column, otherwise it holds the current one.
  assign raddr = acc_i ? col_next : col_q;

  mssq_ram #(
    .Width (SideW),
    .Depth (MAX_WIDTH)
  ) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (acc_i),
    .waddr_i (col_q),
    .wdata_i (side),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // A write and a read of the same entry in one cycle return the old
  // entry from the RAM, so the new side is forwarded from here instead.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_vld_q <= 1'b0;
    end else begin
      byp_vld_q <= acc_i && (raddr == col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    byp_q <= side;
  end

  assign up = byp_vld_q ? byp_q : rdata;

  assign first  = (row_q == '0) || (col_q == '0);
  assign nb_min = min3(up, left_q, diag_q);

  always_comb begin
    if (first) begin
      side = {{(SideW-1){1'b0}}, pixel_i};
    end else if (pixel_i) begin
      side = (nb_min == SideMax) ? SideMax : nb_min + 1'b1;
    end else begin
      side = '0;
    end
  end

  assign best_new = (side > best_q) ? side : best_q;

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    left_d = left_q;
    diag_d = diag_q;
    best_d = best_q;
    if (acc_i) begin
      col_d  = col_next;
      left_d = row_end ? '0 : side;
      diag_d = row_end ? '0 : up;
      best_d = frame_end ? '0 : best_new;
      if (row_end) begin
        row_d = frame_end ? '0 : row_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      left_q <= '0;
      diag_q <= '0;
      best_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      left_q <= left_d;
      diag_q <= diag_d;
      best_q <= best_d;
    end
  end

  assign res_o.side_here  = side;
  assign res_o.best_side  = best_new;
  assign res_o.frame_done = frame_end;

`ifndef SYNTH
  a_frame_clears_best : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && frame_end |=> (best_q == '0) && (row_q == '0) && (col_q == '0))
    else $error("running best or counters not cleared at frame end");

  a_row_end_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && row_end |=> (col_q == '0) && (left_q == '0) && (diag_q == '0))
    else $error("row state not cleared at row end");

  a_best_monotonic : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && !frame_end |=> best_q >= $past(best_q))
    else $error("running best fell within a frame");
`endif

endmodule

`default_nettype wire

>>> rtl/core/mssq_obuf.sv
`default_nettype none

module mssq_obuf
  import mssq_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              acc_i,
  input  wire res_t              res_i,
  output logic                   full_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic       [SideW-1:0] side_here_o,
  output logic       [SideW-1:0] best_side_o,
  output logic       [AreaW-1:0] best_area_o,
  output logic                   frame_done_o
);

  logic                 out_vld_q, out_vld_d, skid_vld_q, skid_vld_d;
  res_t                 out_q, out_d, skid_q, skid_d;
  logic                 out_free;
  logic [2*SideW-1:0]   sq;

  assign out_free = !out_vld_q || !out_stall_i;

  // Output register with a skid word behind it: a new word is taken
  // while the output word is still waiting, and only a full skid stalls.
  always_comb begin
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    skid_vld_d = skid_vld_q;
    skid_d     = skid_q;
    if (out_free) begin
      out_vld_d  = skid_vld_q || acc_i;
      out_d      = skid_vld_q ? skid_q : res_i;
      skid_vld_d = 1'b0;
    end else if (acc_i) begin
      skid_vld_d = 1'b1;
      skid_d     = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign sq = out_q.best_side * out_q.best_side;

  assign full_o       = skid_vld_q;
  assign out_valid_o  = out_vld_q;
  assign side_here_o  = out_q.side_here;
  assign best_side_o  = out_q.best_side;
  assign best_area_o  = (sq > (2*SideW)'(AreaMax)) ? AreaMax : sq[AreaW-1:0];
  assign frame_done_o = out_q.frame_done;

`ifndef SYNTH
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid word held with an empty output register");

  a_accept_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i |=> out_vld_q)
    else $error("accepted word did not reach the output");

  a_skid_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q && !out_stall_i |=> !skid_vld_q)
    else $error("skid word not moved to the output when it was free");
`endif

endmodule

`default_nettype wire

>>> rtl/core/max_square_of_ones_unit.sv
`default_nettype none

// Each result word is registered, in the skid word if the output word waits.
// One pixel per cycle while the output buffer is not full, set by the
// single line-buffer read port, which is read one column ahead of the pixel
// stream. The two-word output buffer stalls the input only when both words
// wait. Reset clears the counters, neighbour sides, running best and output
// buffer at once; the line buffer is not cleared and needs no clearing pass.
module max_square_of_ones_unit
  import mssq_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = DefMaxHeight
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               pixel_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic      [SideW-1:0]   side_here_o,
  output logic      [SideW-1:0]   best_side_o,
  output logic      [AreaW-1:0]   best_area_o,
  output logic                    frame_done_o
);

  logic acc, full;
  res_t res;

  assign in_stall_o = full;
  assign acc        = in_valid_i && !full;

  mssq_core #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .acc_i       (acc),
    .pixel_i     (pixel_i),
    .res_o       (res)
  );

  mssq_obuf u_obuf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .acc_i        (acc),
    .res_i        (res),
    .full_o       (full),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .side_here_o  (side_here_o),
    .best_side_o  (best_side_o),
    .best_area_o  (best_area_o),
    .frame_done_o (frame_done_o)
  );

endmodule

`default_nettype wire

>>> sim/max_square_of_ones_unit_tb.sv
module max_square_of_ones_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mssq_pkg::*;

  localparam int unsigned MaxW = DefMaxWidth;
  localparam int unsigned MaxH = DefMaxHeight;
  localparam int unsigned RandomPixels = 160;
  localparam int unsigned PartColumn = 40;
  localparam int unsigned LongHold = 300;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned MaxReports = 50;

  typedef struct packed {
    logic [SideW-1:0] side_here;
    logic [SideW-1:0] best_side;
    logic [AreaW-1:0] best_area;
    logic             frame_done;
  } square_result_t;

  typedef enum int {AllOnes, FewZeros, Coin, AllZeros} fill_e;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = CfgImageWidth;
  logic [CfgW-1:0]    cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               pixel_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [SideW-1:0]   side_here_o;
  logic [SideW-1:0]   best_side_o;
  logic [AreaW-1:0]   best_area_o;
  logic               frame_done_o;

  max_square_of_ones_unit #(
    .MAX_WIDTH (MaxW),
    .MAX_HEIGHT(MaxH)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pixel_i     (pixel_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .side_here_o (side_here_o),
    .best_side_o (best_side_o),
    .best_area_o (best_area_o),
    .frame_done_o(frame_done_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the block: line buffer, neighbour sides, counters and registers.
  logic [SideW-1:0] line_sides [MaxW];
  bit               line_written [MaxW];
  logic [SideW-1:0] left_side;
  logic [SideW-1:0] diag_side;
  logic [SideW-1:0] best_side;
  logic [9:0]       col_cnt;
  logic [9:0]       row_cnt;
  logic [CfgW-1:0]  img_width;
  logic [CfgW-1:0]  img_height;

  square_result_t expected_squares [$];
  logic           pixel_q [$];

  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;
  int unsigned pattern_left = 0;
  logic [7:0]  stall_pattern = '0;
  int unsigned words_seen = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  function automatic int unsigned dim_limit(input logic [CfgW-1:0] v, input int unsigned top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  // Number of line-buffer columns, counted from column 0, that hold a real side.
  function automatic int unsigned written_span();
    int unsigned n;
    n = 0;
    while (n < MaxW && line_written[n]) n++;
    return n;
  endfunction

  function automatic void compute_square(input logic px);
    int unsigned w, h, col, up, side, low, area;
    logic row_end, frame_end;
    square_result_t res;
    w = dim_limit(img_width, MaxW);
    h = dim_limit(img_height, MaxH);
    col = (col_cnt < MaxW) ? col_cnt : MaxW - 1;
    up = line_sides[col];
    row_end = (col_cnt + 1 >= w);
    frame_end = row_end && (row_cnt + 1 >= h);
    if (row_cnt == 0 || col_cnt == 0) begin
      side = px;
    end else if (px) begin
      low = (up < left_side) ? up : left_side;
      if (diag_side < low) low = diag_side;
      side = low + 1;
      if (side > SideMax) side = SideMax;
    end else begin
      side = 0;
    end
    diag_side = SideW'(up);
    left_side = SideW'(side);
    line_sides[col] = SideW'(side);
    line_written[col] = 1'b1;
    if (side > best_side) best_side = SideW'(side);
    area = best_side;
    area = area * area;
    res.side_here = SideW'(side);
    res.best_side = best_side;
    res.best_area = (area > AreaMax) ? AreaMax : AreaW'(area);
    res.frame_done = frame_end;
    expected_squares.push_back(res);
    if (row_end) begin
      col_cnt = '0;
      left_side = '0;
      diag_side = '0;
      if (frame_end) begin
        row_cnt = '0;
        best_side = '0;
      end else begin
        row_cnt++;
      end
    end else begin
      col_cnt++;
    end
  endfunction

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= MaxReports) $display("[%0t] %s", $time, msg);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pixel_q.size() != 0 || in_valid_i || expected_squares.size() != 0);
  endtask

  task automatic write_regs(input logic [CfgW-1:0] w, input logic [CfgW-1:0] h);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CfgImageWidth;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    img_width = w;
    cfg_idx_i <= CfgImageHeight;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    img_height = h;
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_pixels(input int unsigned n, input fill_e fill);
    repeat (n) begin
      case (fill)
        AllOnes:  pixel_q.push_back(1'b1);
        FewZeros: pixel_q.push_back($urandom_range(0, 7) != 0);
        Coin:     pixel_q.push_back(1'($urandom_range(0, 1)));
        default:  pixel_q.push_back(1'b0);
      endcase
    end
  endtask

  function automatic logic [CfgW-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 1;
      2: return 2;
      default: return CfgW'($urandom_range(3, 16));
    endcase
  endfunction

  function automatic fill_e pick_fill();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return AllOnes;
      4, 5, 6:    return FewZeros;
      7, 8:       return Coin;
      default:    return AllZeros;
    endcase
  endfunction

  // Sender: offers pixels in bursts and leaves random gaps between them.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      pixel_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) compute_square(pixel_i);
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pixel_q.size() != 0) begin
          in_valid_i <= 1'b1;
          pixel_i <= pixel_q.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 48);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result word and stalls on a rotating pattern,
  // with a long hold-off whenever one is requested.
  always @(posedge clk_i or negedge rst_ni) begin
    square_result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_pattern <= '0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_squares.size() == 0) begin
          flag_error($sformatf("word %0d arrived with nothing expected", words_seen));
        end else begin
          want = expected_squares.pop_front();
          if (side_here_o !== want.side_here)
            flag_error($sformatf("word %0d side_here %0d, expected %0d",
                                 words_seen, side_here_o, want.side_here));
          if (best_side_o !== want.best_side)
            flag_error($sformatf("word %0d best_side %0d, expected %0d",
                                 words_seen, best_side_o, want.best_side));
          if (best_area_o !== want.best_area)
            flag_error($sformatf("word %0d best_area %0d, expected %0d",
                                 words_seen, best_area_o, want.best_area));
          if (frame_done_o !== want.frame_done)
            flag_error($sformatf("word %0d frame_done %b, expected %b",
                                 words_seen, frame_done_o, want.frame_done));
        end
        words_seen++;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left = LongHold;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= stall_pattern[0];
        if (pattern_left == 0) begin
          pattern_left = $urandom_range(16, 200);
          case ($urandom_range(0, 2))
            0:       stall_pattern <= '0;
            1:       stall_pattern <= 8'($urandom);
            default: stall_pattern <= 8'($urandom | $urandom);
          endcase
        end else begin
          pattern_left--;
          stall_pattern <= {stall_pattern[0], stall_pattern[7:1]};
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [CfgW-1:0] w_sel, h_sel;
    int unsigned cells, random_pixels, phase;
    for (int i = 0; i < MaxW; i++) begin
      line_sides[i] = '0;
      line_written[i] = 1'b0;
    end
    left_side = '0;
    diag_side = '0;
    best_side = '0;
    col_cnt = '0;
    row_cnt = '0;
    img_width = ResetImageWidth;
    img_height = ResetImageHeight;
    random_pixels = 0;
    phase = 0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // A few pixels into the first row of a full-size frame after reset.
    pixel_q.push_back(1'b1);
    pixel_q.push_back(1'b1);
    pixel_q.push_back(1'b0);
    pixel_q.push_back(1'b1);

    // Shrinking the width mid-row ends that row at once; the rest is a 3x3 frame
    // whose last pixel is a zero next to non-zero neighbours.
    wait_idle();
    write_regs(3, 3);
    repeat (6) pixel_q.push_back(1'b1);
    pixel_q.push_back(1'b0);

    // Single-pixel frames: every word ends a frame and the best side restarts.
    wait_idle();
    write_regs(1, 1);
    pixel_q.push_back(1'b1);
    pixel_q.push_back(1'b0);

    wait_idle();
    write_regs(2, 2);
    repeat (4) pixel_q.push_back(1'b1);
    pixel_q.push_back(1'b0);
    repeat (3) pixel_q.push_back(1'b1);

    // Out-of-range registers: oversize width acts as the full width and zero
    // height as one row. The receiver holds off meanwhile so the block backs up.
    wait_idle();
    write_regs(CfgW'(MaxW + 1), '0);
    queue_pixels(MaxW, FewZeros);
    @(negedge clk_i);
    hold_requests++;

    // Oversize height in a single column; the frame is left open here.
    wait_idle();
    write_regs(1, '1);
    queue_pixels(PartColumn, Coin);

    while (random_pixels < RandomPixels) begin
      wait_idle();
      w_sel = pick_dim();
      h_sel = pick_dim();
      // Growing the width mid-frame must not reach columns never written.
      if (row_cnt != 0 && dim_limit(w_sel, MaxW) > written_span())
        w_sel = CfgW'(written_span());
      write_regs(w_sel, h_sel);
      cells = dim_limit(w_sel, MaxW) * dim_limit(h_sel, MaxH);
      repeat ($urandom_range(1, 3)) begin
        queue_pixels(cells, pick_fill());
        random_pixels += cells;
      end
      // Sometimes stop part way into a frame, so the next registers land mid-frame.
      if ($urandom_range(0, 2) == 0) begin
        cells = $urandom_range(1, cells);
        queue_pixels(cells, pick_fill());
        random_pixels += cells;
      end
      if (phase == 0) begin
        @(negedge clk_i);
        hold_requests++;
      end
      phase++;
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && expected_squares.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
